### rtl/ftc_pkg.sv
// Shared types and constants for the file name token classifier.
package ftc_pkg;

  typedef logic [7:0] byte_t;

  // Configuration register indexes and port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_DOT_REQUIRED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_NAME_CHARS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_EXT_CHARS  = 2'd2;

  localparam int NAME_CNT_W = 5;
  localparam int EXT_CNT_W  = 3;
  localparam int LEN_W      = 8;
  localparam int START_W    = 16;

  localparam logic [NAME_CNT_W-1:0] NAME_CNT_SAT = '1;
  localparam logic [EXT_CNT_W-1:0]  EXT_CNT_SAT  = '1;
  localparam logic [LEN_W-1:0]      LEN_SAT      = '1;

  localparam logic                  DOT_REQUIRED_RST   = 1'b1;
  localparam logic [NAME_CNT_W-1:0] MAX_NAME_CHARS_RST = 5'd20;
  localparam logic [EXT_CNT_W-1:0]  MAX_EXT_CHARS_RST  = 3'd3;

  // Longest word that can pass: full name, the dot, full extension
  localparam int MAX_VALID_LEN = (2 ** NAME_CNT_W - 2) + 1 + (2 ** EXT_CNT_W - 2);

  // Separators
  localparam byte_t CH_NUL   = 8'h00;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_COMMA = 8'h2C;
  localparam byte_t CH_COLON = 8'h3A;
  localparam byte_t CH_SEMI  = 8'h3B;

  // Word characters
  localparam byte_t CH_DOT    = 8'h2E;
  localparam byte_t CH_DOLLAR = 8'h24;
  localparam byte_t CH_PCT    = 8'h25;
  localparam byte_t CH_QUOTE  = 8'h27;
  localparam byte_t CH_DASH   = 8'h2D;
  localparam byte_t CH_UNDER  = 8'h5F;
  localparam byte_t CH_AT     = 8'h40;
  localparam byte_t CH_LBRACE = 8'h7B;
  localparam byte_t CH_RBRACE = 8'h7D;
  localparam byte_t CH_TILDE  = 8'h7E;
  localparam byte_t CH_BTICK  = 8'h60;
  localparam byte_t CH_BANG   = 8'h21;
  localparam byte_t CH_HASH   = 8'h23;
  localparam byte_t CH_LPAREN = 8'h28;
  localparam byte_t CH_RPAREN = 8'h29;
  localparam byte_t CH_STAR   = 8'h2A;
  localparam byte_t CH_QMARK  = 8'h3F;
  localparam byte_t CH_0      = 8'h30;
  localparam byte_t CH_9      = 8'h39;
  localparam byte_t CH_UP_A   = 8'h41;
  localparam byte_t CH_UP_Z   = 8'h5A;
  localparam byte_t CH_LOW_A  = 8'h61;
  localparam byte_t CH_LOW_Z  = 8'h7A;

  typedef struct packed {
    logic is_sep;
    logic is_ok;
    logic is_dot;
  } char_class_t;

endpackage

### rtl/ftc_if.sv
// Handshake channel interfaces: text input, result output, configuration writes.
interface ftc_in_if import ftc_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t text_byte;
  logic  last;

  modport source (output valid, output text_byte, output last, input ready);
  modport sink (input valid, input text_byte, input last, output ready);
endinterface

interface ftc_out_if import ftc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               is_filename;
  logic [START_W-1:0] word_start;
  logic [LEN_W-1:0]   word_length;

  modport source (output valid, output is_filename, output word_start,
                  output word_length, input ready);
  modport sink (input valid, input is_filename, input word_start,
                input word_length, output ready);
endinterface

interface ftc_cfg_if import ftc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/ftc_char_class.sv
// Character class decode: separator, allowed file name character, dot.
module ftc_char_class import ftc_pkg::*; (
  input  byte_t       char_i,
  output char_class_t cls_o
);

  always_comb begin
    cls_o = '0;
    case (char_i) inside
      CH_NUL, CH_TAB, CH_LF, CH_SPACE, CH_COMMA, CH_COLON, CH_SEMI: begin
        cls_o.is_sep = 1'b1;
      end
      CH_DOT: begin
        cls_o.is_ok  = 1'b1;
        cls_o.is_dot = 1'b1;
      end
      [CH_0:CH_9], [CH_UP_A:CH_UP_Z], [CH_LOW_A:CH_LOW_Z],
      CH_DOLLAR, CH_PCT, CH_QUOTE, CH_DASH, CH_UNDER, CH_AT, CH_LBRACE,
      CH_RBRACE, CH_TILDE, CH_BTICK, CH_BANG, CH_HASH, CH_LPAREN,
      CH_RPAREN, CH_STAR, CH_QMARK: begin
        cls_o.is_ok = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### rtl/filename_token_classifier.sv
// Top level: splits a byte stream into words and judges each as a file name.
// A byte is taken into the input register; the word it closes then loads its result into the result register.
// Throughput: one byte per cycle; the input stalls only while a finished result
// waits in the output register and a byte in the input register closes another word.
// Reset (rst_n low, synchronous) empties both registers, closes any open word,
// sets the position to zero and loads the configuration reset values.
module filename_token_classifier import ftc_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ftc_in_if.sink    in_bus,
  ftc_out_if.source out_bus,
  ftc_cfg_if.sink   cfg_bus
);

  // Configuration
  logic                  dot_required_r;
  logic [NAME_CNT_W-1:0] max_name_chars_r;
  logic [EXT_CNT_W-1:0]  max_ext_chars_r;

  // Input register
  logic  s1_valid_r;
  byte_t s1_byte_r;
  logic  s1_last_r;

  // Word state
  logic                     in_word_r, in_word_nxt;
  logic                     dot_seen_r, dot_seen_nxt;
  logic                     word_bad_r, word_bad_nxt;
  logic [NAME_CNT_W-1:0]    name_count_r, name_count_nxt;
  logic [EXT_CNT_W-1:0]     ext_count_r, ext_count_nxt;
  logic [LEN_W-1:0]         length_count_r, length_count_nxt;
  logic [POSITION_BITS-1:0] start_pos_r, start_pos_nxt;
  logic [POSITION_BITS-1:0] position_r, position_nxt;

  // Values after this byte, before any close
  logic                     upd_dot_seen, upd_bad;
  logic [NAME_CNT_W-1:0]    upd_name;
  logic [EXT_CNT_W-1:0]     upd_ext;
  logic [LEN_W-1:0]         upd_len;
  logic [POSITION_BITS-1:0] upd_start;

  // Result register
  logic               out_valid_r;
  logic               is_filename_r;
  logic [START_W-1:0] word_start_r;
  logic [LEN_W-1:0]   word_length_r;

  char_class_t cls;
  logic        close_word;
  logic        verdict;
  logic        out_free;
  logic        s1_go;

  ftc_char_class u_char_class (
    .char_i (s1_byte_r),
    .cls_o  (cls)
  );

  assign cfg_bus.ready = 1'b1;

  always_comb begin
    upd_dot_seen = dot_seen_r;
    upd_bad      = word_bad_r;
    upd_name     = name_count_r;
    upd_ext      = ext_count_r;
    upd_len      = length_count_r;
    upd_start    = start_pos_r;
    close_word   = 1'b0;
    if (cls.is_sep) begin
      close_word = in_word_r;
    end else begin
      if (!in_word_r) begin
        upd_dot_seen = 1'b0;
        upd_bad      = 1'b0;
        upd_name     = '0;
        upd_ext      = '0;
        upd_len      = '0;
        upd_start    = position_r;
      end
      if (!cls.is_ok) begin
        upd_bad = 1'b1;
      end else if (cls.is_dot) begin
        if (upd_dot_seen) begin
          upd_bad = 1'b1;
        end
        upd_dot_seen = 1'b1;
      end else if (upd_dot_seen) begin
        if (upd_ext != EXT_CNT_SAT) begin
          upd_ext = upd_ext + 1'b1;
        end
      end else if (upd_name != NAME_CNT_SAT) begin
        upd_name = upd_name + 1'b1;
      end
      if (upd_len != LEN_SAT) begin
        upd_len = upd_len + 1'b1;
      end
      close_word = s1_last_r;
    end
  end

  // Saturated counts always fail, so the register maxima 31 and 7 act as 30 and 6
  assign verdict = !upd_bad &&
                   (upd_name != '0) && (upd_name != NAME_CNT_SAT) &&
                   (upd_name <= max_name_chars_r) &&
                   (upd_ext != EXT_CNT_SAT) && (upd_ext <= max_ext_chars_r) &&
                   !(dot_required_r && (upd_ext == '0));

  always_comb begin
    if (close_word || s1_last_r) begin
      in_word_nxt      = 1'b0;
      dot_seen_nxt     = 1'b0;
      word_bad_nxt     = 1'b0;
      name_count_nxt   = '0;
      ext_count_nxt    = '0;
      length_count_nxt = '0;
      start_pos_nxt    = '0;
    end else begin
      in_word_nxt      = in_word_r || !cls.is_sep;
      dot_seen_nxt     = upd_dot_seen;
      word_bad_nxt     = upd_bad;
      name_count_nxt   = upd_name;
      ext_count_nxt    = upd_ext;
      length_count_nxt = upd_len;
      start_pos_nxt    = upd_start;
    end
    position_nxt = s1_last_r ? '0 : position_r + 1'b1;
  end

  assign out_free     = !out_valid_r || out_bus.ready;
  assign s1_go        = s1_valid_r && (!close_word || out_free);
  assign in_bus.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_required_r   <= DOT_REQUIRED_RST;
      max_name_chars_r <= MAX_NAME_CHARS_RST;
      max_ext_chars_r  <= MAX_EXT_CHARS_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        REG_DOT_REQUIRED:   dot_required_r   <= cfg_bus.data[0];
        REG_MAX_NAME_CHARS: max_name_chars_r <= cfg_bus.data[NAME_CNT_W-1:0];
        REG_MAX_EXT_CHARS:  max_ext_chars_r  <= cfg_bus.data[EXT_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      s1_byte_r <= in_bus.text_byte;
      s1_last_r <= in_bus.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_word_r      <= 1'b0;
      dot_seen_r     <= 1'b0;
      word_bad_r     <= 1'b0;
      name_count_r   <= '0;
      ext_count_r    <= '0;
      length_count_r <= '0;
      start_pos_r    <= '0;
      position_r     <= '0;
    end else if (s1_go) begin
      in_word_r      <= in_word_nxt;
      dot_seen_r     <= dot_seen_nxt;
      word_bad_r     <= word_bad_nxt;
      name_count_r   <= name_count_nxt;
      ext_count_r    <= ext_count_nxt;
      length_count_r <= length_count_nxt;
      start_pos_r    <= start_pos_nxt;
      position_r     <= position_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && close_word) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && close_word) begin
      is_filename_r <= verdict;
      word_start_r  <= START_W'(upd_start);
      word_length_r <= upd_len;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.is_filename = is_filename_r;
  assign out_bus.word_start  = word_start_r;
  assign out_bus.word_length = word_length_r;

endmodule

### rtl/ftc_checker.sv
// Port-level checks for the file name token classifier, bound to the top level.
module ftc_checker import ftc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               is_filename,
  input logic [START_W-1:0] word_start,
  input logic [LEN_W-1:0]   word_length
);

  // A held result keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(is_filename) &&
      $stable(word_start) && $stable(word_length))
    else $error("result changed while stalled");

  // Every closed word holds at least one byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> word_length != '0)
    else $error("result with empty word");

  // A passing name cannot exceed name, dot and extension limits
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_filename |-> word_length <= LEN_W'(MAX_VALID_LEN))
    else $error("valid file name too long");

  // A fresh result comes from a byte that was taken on the input port before it
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching input transaction");

endmodule

bind filename_token_classifier ftc_checker u_ftc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .is_filename (out_bus.is_filename),
  .word_start  (out_bus.word_start),
  .word_length (out_bus.word_length)
);

### tb/filename_token_classifier_test.sv
// Testbench for filename_token_classifier: directed table, then random texts per register setting.
module filename_token_classifier_test import ftc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 600_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BYTES   = 100;
  localparam int N_PHASES      = 14;
  localparam int N_FIXED       = 9;
  localparam int REPORT_MAX    = 10;

  // Index past the register list; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic               ok;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } verdict_t;

  typedef struct packed {
    byte_t    ch;
    logic     lst;
    logic     typed;
    verdict_t v;
  } dir_row_t;

  localparam verdict_t NO_V = '0;

  localparam byte_t SEPS [7] = '{CH_NUL, CH_TAB, CH_LF, CH_SPACE, CH_COMMA, CH_COLON, CH_SEMI};
  localparam byte_t PUNCT [16] = '{CH_DOLLAR, CH_PCT, CH_QUOTE, CH_DASH, CH_UNDER, CH_AT,
                                   CH_LBRACE, CH_RBRACE, CH_TILDE, CH_BTICK, CH_BANG, CH_HASH,
                                   CH_LPAREN, CH_RPAREN, CH_STAR, CH_QMARK};

  // Runs under reset register values: dot required, 20 name chars, 3 ext chars
  localparam dir_row_t DIRECTED [25] = '{
    '{CH_LOW_A,  1'b0, 1'b0, NO_V},
    '{CH_DOT,    1'b0, 1'b0, NO_V},
    '{8'h63,     1'b0, 1'b0, NO_V},
    '{CH_SPACE,  1'b0, 1'b1, '{1'b1, 16'd0, 8'd3}},
    '{CH_COMMA,  1'b0, 1'b0, NO_V},
    '{CH_UP_A,   1'b0, 1'b0, NO_V},
    '{CH_UP_Z,   1'b0, 1'b0, NO_V},
    '{CH_SEMI,   1'b0, 1'b1, '{1'b0, 16'd5, 8'd2}},
    '{CH_0,      1'b0, 1'b0, NO_V},
    '{CH_DOT,    1'b0, 1'b0, NO_V},
    '{CH_DOT,    1'b0, 1'b0, NO_V},
    '{CH_9,      1'b0, 1'b0, NO_V},
    '{CH_TAB,    1'b0, 1'b1, '{1'b0, 16'd8, 8'd4}},
    '{8'hFF,     1'b0, 1'b0, NO_V},
    '{CH_COLON,  1'b0, 1'b1, '{1'b0, 16'd13, 8'd1}},
    '{CH_TILDE,  1'b0, 1'b0, NO_V},
    '{CH_DOT,    1'b0, 1'b0, NO_V},
    '{CH_LOW_Z,  1'b0, 1'b0, NO_V},
    '{CH_NUL,    1'b0, 1'b1, '{1'b1, 16'd15, 8'd3}},
    '{CH_LF,     1'b0, 1'b0, NO_V},
    '{CH_DOT,    1'b0, 1'b0, NO_V},
    '{CH_QMARK,  1'b0, 1'b0, NO_V},
    '{8'h78,     1'b1, 1'b1, '{1'b0, 16'd20, 8'd3}},
    '{CH_LBRACE, 1'b0, 1'b0, NO_V},
    '{CH_SPACE,  1'b1, 1'b1, '{1'b0, 16'd0, 8'd1}}
  };

  localparam logic DREQ_SET [N_FIXED] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                                          1'b1};
  localparam logic [NAME_CNT_W-1:0] NMAX_SET [N_FIXED] = '{5'd20, 5'd1, 5'd30, 5'd31, 5'd0,
                                                           5'd5, 5'd8, 5'd12, 5'd3};
  localparam logic [EXT_CNT_W-1:0]  EMAX_SET [N_FIXED] = '{3'd3, 3'd0, 3'd6, 3'd7, 3'd0,
                                                           3'd1, 3'd2, 3'd4, 3'd5};

  logic clk;
  logic rst_n;

  ftc_in_if  in_bus ();
  ftc_out_if out_bus ();
  ftc_cfg_if cfg_bus ();

  filename_token_classifier u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // Register shadow
  logic                  cfg_dot_req  = DOT_REQUIRED_RST;
  logic [NAME_CNT_W-1:0] cfg_name_max = MAX_NAME_CHARS_RST;
  logic [EXT_CNT_W-1:0]  cfg_ext_max  = MAX_EXT_CHARS_RST;

  // Word tracker state
  logic               w_open  = 1'b0;
  logic               w_dot   = 1'b0;
  logic               w_bad   = 1'b0;
  logic [NAME_CNT_W-1:0] w_name = '0;
  logic [EXT_CNT_W-1:0]  w_ext  = '0;
  logic [LEN_W-1:0]   w_len   = '0;
  logic [START_W-1:0] w_start = '0;
  logic [START_W-1:0] text_pos = '0;

  verdict_t verdict_q [$];

  bit in_idle  = 1'b1;
  bit out_idle = 1'b1;
  int bytes_sent    = 0;
  int verdicts_seen = 0;
  int good_names    = 0;
  int settings_run  = 1;
  int mismatches    = 0;
  int cycles        = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still awaited", cycles, verdict_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic is_sep(byte_t b);
    return b inside {CH_NUL, CH_TAB, CH_LF, CH_SPACE, CH_COMMA, CH_COLON, CH_SEMI};
  endfunction

  function automatic logic is_name_char(byte_t b);
    return (b >= CH_LOW_A && b <= CH_LOW_Z) || (b >= CH_UP_A && b <= CH_UP_Z) ||
           (b >= CH_0 && b <= CH_9) || b == CH_DOT ||
           b inside {CH_DOLLAR, CH_PCT, CH_QUOTE, CH_DASH, CH_UNDER, CH_AT, CH_LBRACE,
                     CH_RBRACE, CH_TILDE, CH_BTICK, CH_BANG, CH_HASH, CH_LPAREN,
                     CH_RPAREN, CH_STAR, CH_QMARK};
  endfunction

  function automatic byte_t pick_char();
    int k;
    k = $urandom_range(0, 77);
    if (k < 26) return byte_t'(CH_LOW_A + k);
    if (k < 52) return byte_t'(CH_UP_A + k - 26);
    if (k < 62) return byte_t'(CH_0 + k - 52);
    return PUNCT[k - 62];
  endfunction

  function automatic byte_t pick_sep();
    return SEPS[$urandom_range(0, 6)];
  endfunction

  function automatic verdict_t close_verdict();
    verdict_t v;
    // Saturated counters always fail, whatever the limit register says
    v.ok = !w_bad && w_name != 0 && w_name != NAME_CNT_SAT && w_name <= cfg_name_max &&
           w_ext != EXT_CNT_SAT && w_ext <= cfg_ext_max && !(cfg_dot_req && w_ext == 0);
    v.start = w_start;
    v.len   = w_len;
    return v;
  endfunction

  task automatic clear_word();
    w_open  = 1'b0;
    w_dot   = 1'b0;
    w_bad   = 1'b0;
    w_name  = '0;
    w_ext   = '0;
    w_len   = '0;
    w_start = '0;
  endtask

  task automatic classify_byte(input byte_t b, input logic lst, output logic hit,
                               output verdict_t v);
    hit = 1'b0;
    v = NO_V;
    if (is_sep(b)) begin
      if (w_open) begin
        hit = 1'b1;
        v = close_verdict();
        clear_word();
      end
    end else begin
      if (!w_open) begin
        clear_word();
        w_open  = 1'b1;
        w_start = text_pos;
      end
      if (!is_name_char(b)) begin
        w_bad = 1'b1;
      end else if (b == CH_DOT) begin
        if (w_dot) w_bad = 1'b1;
        w_dot = 1'b1;
      end else if (w_dot) begin
        if (w_ext != EXT_CNT_SAT) w_ext = w_ext + 1'b1;
      end else begin
        if (w_name != NAME_CNT_SAT) w_name = w_name + 1'b1;
      end
      if (w_len != LEN_SAT) w_len = w_len + 1'b1;
      if (lst) begin
        hit = 1'b1;
        v = close_verdict();
      end
    end
    // The last byte ends the text: position restarts at zero
    if (lst) begin
      clear_word();
      text_pos = '0;
    end else begin
      text_pos = text_pos + 1'b1;
    end
  endtask

  task automatic push_byte(input byte_t b, input logic lst, input logic typed,
                           input verdict_t typed_v);
    int gap;
    logic hit;
    verdict_t v;
    gap = in_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.text_byte <= b;
    in_bus.last      <= lst;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    classify_byte(b, lst, hit, v);
    bytes_sent++;
    if (typed) verdict_q.push_back(typed_v);
    else if (hit) verdict_q.push_back(v);
  endtask

  // Hold the input until every word has come back, then let the pipeline settle
  task automatic drain_words();
    in_bus.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    case (idx)
      REG_DOT_REQUIRED:   cfg_dot_req  = val[0];
      REG_MAX_NAME_CHARS: cfg_name_max = val[NAME_CNT_W-1:0];
      REG_MAX_EXT_CHARS:  cfg_ext_max  = val[EXT_CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic dreq, input logic [NAME_CNT_W-1:0] nmax,
                            input logic [EXT_CNT_W-1:0] emax);
    logic [CFG_DATA_W-1:0] d;
    drain_words();
    // Upper data bits are random; only the register width may count
    d = CFG_DATA_W'($urandom_range(0, 255));
    d[0] = dreq;
    write_reg(REG_DOT_REQUIRED, d);
    d = CFG_DATA_W'($urandom_range(0, 255));
    d[NAME_CNT_W-1:0] = nmax;
    write_reg(REG_MAX_NAME_CHARS, d);
    d = CFG_DATA_W'($urandom_range(0, 255));
    d[EXT_CNT_W-1:0] = emax;
    write_reg(REG_MAX_EXT_CHARS, d);
    if ($urandom_range(0, 1) == 1) write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 255)));
    cfg_bus.valid <= 1'b0;
    settings_run++;
  endtask

  task automatic send_word(input int name_len, input int ext_len, input bit with_dot,
                           input bit corrupt, input bit close_last);
    byte_t chars [$];
    byte_t junk;
    int k;
    for (k = 0; k < name_len; k++) chars.push_back(pick_char());
    if (with_dot) begin
      chars.push_back(CH_DOT);
      for (k = 0; k < ext_len; k++) chars.push_back(pick_char());
    end
    if (chars.size() == 0) chars.push_back(pick_char());
    if (corrupt) begin
      // Either a random non-separator byte or a dot overwrites one character
      if ($urandom_range(0, 1) == 1) begin
        do junk = byte_t'($urandom_range(0, 255)); while (is_sep(junk));
      end else begin
        junk = CH_DOT;
      end
      chars[$urandom_range(0, chars.size() - 1)] = junk;
    end
    foreach (chars[i]) push_byte(chars[i], close_last && (i == chars.size() - 1), 1'b0, NO_V);
  endtask

  task automatic send_text();
    int words;
    int mode;
    int k;
    bit final_w;
    bit closed;
    words  = $urandom_range(1, 8);
    mode   = $urandom_range(0, 2);
    closed = 1'b0;
    for (k = 0; k < words; k++) begin
      final_w = (k == words - 1);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) push_byte(byte_t'($urandom_range(0, 255)), 1'b0, 1'b0, NO_V);
        push_byte(pick_sep(), 1'b0, 1'b0, NO_V);
      end else begin
        send_word($urandom_range(0, int'(cfg_name_max) + 2),
                  $urandom_range(0, int'(cfg_ext_max) + 2),
                  $urandom_range(0, 3) != 0, $urandom_range(0, 7) == 0,
                  final_w && mode == 0);
        if (final_w && mode == 0) closed = 1'b1;
        else if (!(final_w && mode == 1)) begin
          repeat ($urandom_range(1, 2)) push_byte(pick_sep(), 1'b0, 1'b0, NO_V);
        end
      end
    end
    // Close the text on a separator, with or without a word still open
    if (!closed) push_byte(pick_sep(), 1'b1, 1'b0, NO_V);
  endtask

  // Result side: random stall before each transaction when out_idle is set, check at acceptance
  initial begin
    int stall;
    verdict_t exp_v;
    forever begin
      stall = out_idle ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("Unexpected word: ok=%0b start=%0d len=%0d", out_bus.is_filename,
                   out_bus.word_start, out_bus.word_length);
      end else begin
        exp_v = verdict_q.pop_front();
        if (out_bus.is_filename === 1'b1) good_names++;
        if (out_bus.is_filename !== exp_v.ok || out_bus.word_start !== exp_v.start ||
            out_bus.word_length !== exp_v.len) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("Word mismatch: expected ok=%0b start=%0d len=%0d, got ok=%0b start=%0d len=%0d",
                     exp_v.ok, exp_v.start, exp_v.len, out_bus.is_filename,
                     out_bus.word_start, out_bus.word_length);
        end
      end
    end
  end

  initial begin
    int sent0;
    bit paused;
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.text_byte <= '0;
    in_bus.last      <= 1'b0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= '0;
    cfg_bus.data     <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) push_byte(DIRECTED[i].ch, DIRECTED[i].lst, DIRECTED[i].typed,
                                    DIRECTED[i].v);

    for (int p = 0; p < N_PHASES; p++) begin
      if (p < N_FIXED) set_limits(DREQ_SET[p], NMAX_SET[p], EMAX_SET[p]);
      else set_limits(1'($urandom_range(0, 1)), NAME_CNT_W'($urandom_range(0, 31)),
                      EXT_CNT_W'($urandom_range(0, 7)));
      in_idle  = $urandom_range(0, 2) != 0;
      out_idle = $urandom_range(0, 2) != 0;
      // Overlong word: length saturates, name counter saturates
      if (p == 2) send_word(250, 40, 1'b1, 1'b0, 1'b1);
      sent0  = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - sent0 < PHASE_BYTES) begin
        send_text();
        if (!paused && bytes_sent - sent0 >= PHASE_BYTES / 2) begin
          drain_words();
          paused = 1'b1;
        end
      end
    end

    drain_words();
    mismatches += verdict_q.size();
    $display("Sent %0d bytes under %0d register settings; %0d words checked, %0d valid names",
             bytes_sent, settings_run, verdicts_seen, good_names);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/ftc_pkg.sv
rtl/ftc_if.sv
rtl/ftc_char_class.sv
rtl/filename_token_classifier.sv
rtl/ftc_checker.sv
tb/filename_token_classifier_test.sv
